// ===== rtl/core/ttn_pkg.sv =====
// Shared types, widths and truth-table mask permutations for the
// truth-table normalizer. No dependencies.
`default_nettype none

package ttn_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned CntW    = 2;
  localparam int unsigned LitW    = 31;
  localparam int unsigned VarOutW = 31;
  localparam int unsigned MaskW   = 8;

  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [MaskW-1:0] mask_t;
  typedef logic [1:0]       idx_t;

  // Pairwise order flags of the three column variables; gt[{a,b}] is var a > var b
  typedef struct packed {
    logic [15:0] gt;
    logic [2:0]  zero;
  } cmp_t;

  // Normalized count, source column of each output column, and mask
  typedef struct packed {
    cnt_t  count;
    idx_t  src0;
    idx_t  src1;
    idx_t  src2;
    mask_t table_bits;
  } res_t;

  function automatic logic is_gt(cmp_t c, idx_t a, idx_t b);
    return c.gt[{a, b}];
  endfunction

  function automatic logic is_eq(cmp_t c, idx_t a, idx_t b);
    return !c.gt[{a, b}] && !c.gt[{b, a}];
  endfunction

  function automatic logic is_zero(cmp_t c, idx_t a);
    logic z;
    unique case (a)
      2'd0:    z = c.zero[0];
      2'd1:    z = c.zero[1];
      2'd2:    z = c.zero[2];
      default: z = 1'b0;
    endcase
    return z;
  endfunction

  // Invert column 0, 1 or 2 of a mask
  function automatic mask_t mask_neg0(mask_t b);
    return ((b & 8'hf0) >> 4) | ((b & 8'h0f) << 4);
  endfunction

  function automatic mask_t mask_neg1(mask_t b);
    return ((b & 8'hcc) >> 2) | ((b & 8'h33) << 2);
  endfunction

  function automatic mask_t mask_neg2(mask_t b);
    return ((b & 8'haa) >> 1) | ((b & 8'h55) << 1);
  endfunction

  // Exchange two adjacent columns
  function automatic mask_t mask_sw01(mask_t b);
    return (b & 8'hc3) | ((b & 8'h0c) << 2) | ((b & 8'h30) >> 2);
  endfunction

  function automatic mask_t mask_sw12(mask_t b);
    return (b & 8'h99) | ((b & 8'h22) << 1) | ((b & 8'h44) >> 1);
  endfunction

  // Drop a leading column that sits on the constant-true variable
  function automatic mask_t mask_drop_true0(mask_t b);
    return (b & 8'h80) | ((b & 8'hc0) >> 1) | ((b & 8'h60) >> 2) |
           ((b & 8'h30) >> 3) | ((b & 8'h10) >> 4);
  endfunction

  // Merge two equal adjacent columns
  function automatic mask_t mask_join01(mask_t b);
    return (b & 8'h81) | ((b & 8'hc0) >> 1) | ((b & 8'h40) >> 2) |
           ((b & 8'h02) << 2) | ((b & 8'h03) << 1);
  endfunction

  function automatic mask_t mask_join12(mask_t b);
    return (b & 8'h99) | ((b & 8'h88) >> 1) | ((b & 8'h11) << 1);
  endfunction

  // Test whether the function ignores a column
  function automatic logic mask_free0(mask_t b);
    return (b & 8'h0f) == (b >> 4);
  endfunction

  function automatic logic mask_free1(mask_t b);
    return (b & 8'h33) == ((b & 8'hcc) >> 2);
  endfunction

  function automatic logic mask_free2(mask_t b);
    return (b & 8'h55) == ((b & 8'haa) >> 1);
  endfunction

  // Remove an irrelevant leading column
  function automatic mask_t mask_cut0(mask_t b);
    return (b & 8'h81) | ((b & 8'hc0) >> 1) | ((b & 8'h60) >> 2) | ((b & 8'h03) << 1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ttn_compare.sv =====
// Pairwise magnitude and zero compares of the three column variables.
// Depends on ttn_pkg for the flag struct.
`default_nettype none

module ttn_compare
  import ttn_pkg::*;
#(
  parameter int unsigned VarW = 30
) (
  input  wire logic [VarW-1:0] var0_i,
  input  wire logic [VarW-1:0] var1_i,
  input  wire logic [VarW-1:0] var2_i,
  output cmp_t                 cmp_o
);

  // Compare every ordered pair in parallel; unused slots stay low
  always_comb begin
    cmp_o.gt        = '0;
    cmp_o.gt[4'h1]  = var0_i > var1_i;
    cmp_o.gt[4'h2]  = var0_i > var2_i;
    cmp_o.gt[4'h4]  = var1_i > var0_i;
    cmp_o.gt[4'h6]  = var1_i > var2_i;
    cmp_o.gt[4'h8]  = var2_i > var0_i;
    cmp_o.gt[4'h9]  = var2_i > var1_i;
    cmp_o.zero[0]   = var0_i == '0;
    cmp_o.zero[1]   = var1_i == '0;
    cmp_o.zero[2]   = var2_i == '0;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ttn_normalize.sv =====
// Column negation, sort, merge and pruning of the truth-table mask.
// Tracks columns by index only; depends on ttn_pkg for flags and mask ops.
`default_nettype none

module ttn_normalize
  import ttn_pkg::*;
(
  input  wire cnt_t       count_i,
  input  wire logic [2:0] neg_i,
  input  wire mask_t      table_i,
  input  wire cmp_t       cmp_i,
  output res_t            res_o
);

  cnt_t  n;
  mask_t b;
  idx_t  p0;
  idx_t  p1;
  idx_t  p2;
  idx_t  t;

  // Walk the normalization steps in order on column indices and the mask
  always_comb begin
    n  = count_i;
    b  = table_i;
    p0 = 2'd0;
    p1 = 2'd1;
    p2 = 2'd2;
    t  = 2'd0;

    // fold negated columns into the mask
    if (n >= 2'd1 && neg_i[0]) b = mask_neg0(b);
    if (n >= 2'd2 && neg_i[1]) b = mask_neg1(b);
    if (n == 2'd3 && neg_i[2]) b = mask_neg2(b);

    if (n == 2'd1) begin
      if (mask_free0(b)) n = 2'd0;
    end else if (n >= 2'd2) begin
      // sort by variable
      if (is_gt(cmp_i, p0, p1)) begin
        t = p0; p0 = p1; p1 = t; b = mask_sw01(b);
      end
      if (n == 2'd3) begin
        if (is_gt(cmp_i, p1, p2)) begin
          t = p1; p1 = p2; p2 = t; b = mask_sw12(b);
        end
        if (is_gt(cmp_i, p0, p1)) begin
          t = p0; p0 = p1; p1 = t; b = mask_sw01(b);
        end
        if (is_eq(cmp_i, p1, p2)) begin
          n = n - 2'd1; b = mask_join12(b);
        end
      end
      // merge equal leading columns
      if (is_eq(cmp_i, p0, p1)) begin
        n = n - 2'd1; p1 = p2; b = mask_join01(b);
      end
      // drop a column on the constant-true variable
      if (is_zero(cmp_i, p0)) begin
        n = n - 2'd1; p0 = p1; p1 = p2; b = mask_drop_true0(b);
      end
      // remove columns the function does not depend on
      if (n == 2'd3 && mask_free2(b)) n = n - 2'd1;
      if (n > 2'd1 && mask_free1(b)) begin
        n = n - 2'd1; p1 = p2; b = mask_sw12(b);
      end
      if (n > 2'd0 && mask_free0(b)) begin
        n = n - 2'd1; p0 = p1; p1 = p2; b = mask_cut0(b);
      end
    end

    res_o.count      = n;
    res_o.src0       = p0;
    res_o.src1       = p1;
    res_o.src2       = p2;
    res_o.table_bits = b;
  end

endmodule

`default_nettype wire

// ===== rtl/core/truth_table_normalize_core.sv =====
// Top level of the truth-table normalizer: request register, compare and
// normalize logic, result register. Depends on ttn_pkg, ttn_compare, ttn_normalize.
//
//   channel   handshake              payload
//   request   in_valid_i/in_ready_o  column_count_i, *_literal_i, table_bits_i
//   result    out_valid_o/out_ready_i out_column_count_o, *_variable_o, out_table_bits_o
//
// One request per cycle sustained while the result is not stalled; a request
// passes through the request register and then the result register, with a
// single level of parallel 30-bit compares followed by narrow mask permutes
// between them.
// Reset clears both stage valid bits; payload registers are not reset.
// A stalled result holds the result register; the request stage keeps
// accepting while the result stage can advance.
`default_nettype none

module truth_table_normalize_core
  import ttn_pkg::*;
#(
  parameter int unsigned LITERAL_BITS = 31
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire cnt_t                       column_count_i,
  input  wire logic [LitW-1:0]            first_literal_i,
  input  wire logic [LitW-1:0]            second_literal_i,
  input  wire logic [LitW-1:0]            third_literal_i,
  input  wire mask_t                      table_bits_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output cnt_t                            out_column_count_o,
  output logic signed [VarOutW-1:0]       first_variable_o,
  output logic signed [VarOutW-1:0]       second_variable_o,
  output logic signed [VarOutW-1:0]       third_variable_o,
  output mask_t                           out_table_bits_o
);

  localparam int unsigned VarW = LITERAL_BITS - 1;

  logic                    in_valid_q;
  cnt_t                    cnt_q;
  logic [LITERAL_BITS-1:0] lit0_q;
  logic [LITERAL_BITS-1:0] lit1_q;
  logic [LITERAL_BITS-1:0] lit2_q;
  mask_t                   tbl_q;

  logic                    out_valid_q;
  cnt_t                    out_cnt_q;
  logic [VarOutW-1:0]      out_var0_q;
  logic [VarOutW-1:0]      out_var1_q;
  logic [VarOutW-1:0]      out_var2_q;
  mask_t                   out_tbl_q;

  logic [VarOutW-1:0]      out_var0_d;
  logic [VarOutW-1:0]      out_var1_d;
  logic [VarOutW-1:0]      out_var2_d;

  logic [VarW-1:0]         var0;
  logic [VarW-1:0]         var1;
  logic [VarW-1:0]         var2;
  logic                    advance;
  logic                    in_take;
  cmp_t                    cmp;
  res_t                    res;

  // Advance the result stage when it is empty or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Hold stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  // Capture the request, keeping only the used literal bits
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cnt_q  <= column_count_i;
      lit0_q <= first_literal_i[LITERAL_BITS-1:0];
      lit1_q <= second_literal_i[LITERAL_BITS-1:0];
      lit2_q <= third_literal_i[LITERAL_BITS-1:0];
      tbl_q  <= table_bits_i;
    end
  end

  assign var0 = lit0_q[LITERAL_BITS-1:1];
  assign var1 = lit1_q[LITERAL_BITS-1:1];
  assign var2 = lit2_q[LITERAL_BITS-1:1];

  ttn_compare #(
    .VarW (VarW)
  ) u_compare (
    .var0_i (var0),
    .var1_i (var1),
    .var2_i (var2),
    .cmp_o  (cmp)
  );

  ttn_normalize u_normalize (
    .count_i (cnt_q),
    .neg_i   ({lit2_q[0], lit1_q[0], lit0_q[0]}),
    .table_i (tbl_q),
    .cmp_i   (cmp),
    .res_o   (res)
  );

  function automatic logic [VarOutW-1:0] pick_var(idx_t p, logic [VarW-1:0] v0,
                                                  logic [VarW-1:0] v1,
                                                  logic [VarW-1:0] v2);
    logic [VarOutW-1:0] r;
    unique case (p)
      2'd0:    r = VarOutW'(v0);
      2'd1:    r = VarOutW'(v1);
      2'd2:    r = VarOutW'(v2);
      default: r = '1;
    endcase
    return r;
  endfunction

  // Route surviving columns to the outputs; absent columns read as all ones
  always_comb begin
    out_var0_d = (res.count > 2'd0) ? pick_var(res.src0, var0, var1, var2) : '1;
    out_var1_d = (res.count > 2'd1) ? pick_var(res.src1, var0, var1, var2) : '1;
    out_var2_d = (res.count > 2'd2) ? pick_var(res.src2, var0, var1, var2) : '1;
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_cnt_q  <= res.count;
      out_var0_q <= out_var0_d;
      out_var1_q <= out_var1_d;
      out_var2_q <= out_var2_d;
      out_tbl_q  <= res.table_bits;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_column_count_o = out_cnt_q;
  assign first_variable_o   = $signed(out_var0_q);
  assign second_variable_o  = $signed(out_var1_q);
  assign third_variable_o   = $signed(out_var2_q);
  assign out_table_bits_o   = out_tbl_q;

  // Normalization never adds columns
  a_count_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> res.count <= cnt_q)
    else $error("normalized count exceeds request count");

  // A third column beyond the count is marked absent
  a_absent_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_cnt_q != 2'd3 |-> out_var2_q == '1)
    else $error("third variable present beyond count");

  // A full request stage behind a stalled result is kept
  a_hold_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q && $stable(cnt_q))
    else $error("request dropped while result stalled");

  // Back-pressure only when both stages are occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q)
    else $error("request refused with a free stage");

endmodule

`default_nettype wire
